@@ sv/lcdws_pkg.sv @@
// Shared types, constants and the sequencer microcode for the LCD write sequencer.
package lcdws_pkg;

   localparam int FRAME_BITS = 8;
   localparam int PIN_W      = $clog2(FRAME_BITS);
   localparam int WAIT_W     = 14;
   localparam int UPC_W      = 6;
   localparam int NIB_W      = 4;
   localparam int KIND_W     = 3;
   localparam int BYTE_W     = 8;
   localparam int COL_W      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int LOOP_W     = 2;

   localparam logic [KIND_W-1:0] KIND_CMD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DATA  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_GOTO  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
   localparam logic [KIND_W-1:0] KIND_HOME  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_INIT  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_RS_PIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EN_PIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DB4_PIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DB5_PIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DB6_PIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DB7_PIN = 3'd5;

   localparam logic [PIN_W-1:0] RST_RS_PIN  = 3'd0;
   localparam logic [PIN_W-1:0] RST_EN_PIN  = 3'd2;
   localparam logic [PIN_W-1:0] RST_DB4_PIN = 3'd4;
   localparam logic [PIN_W-1:0] RST_DB5_PIN = 3'd5;
   localparam logic [PIN_W-1:0] RST_DB6_PIN = 3'd6;
   localparam logic [PIN_W-1:0] RST_DB7_PIN = 3'd7;

   localparam logic [BYTE_W-1:0] OP_CLEAR    = 8'h01;
   localparam logic [BYTE_W-1:0] OP_HOME     = 8'h02;
   localparam logic [BYTE_W-1:0] OP_DDRAM    = 8'h80;
   localparam logic [BYTE_W-1:0] ROW_OFFSET  = 8'h40;

   localparam logic [WAIT_W-1:0] WAIT_WRITE  = 14'd50;
   localparam logic [WAIT_W-1:0] WAIT_SLOW   = 14'd2000;
   localparam logic [WAIT_W-1:0] WAIT_NIB2   = 14'd1000;
   localparam logic [WAIT_W-1:0] WAIT_WAKE   = 14'd5000;
   localparam logic [WAIT_W-1:0] WAIT_POWER  = 14'd15000;

   localparam logic [UPC_W-1:0]  UPC_BYTE    = 6'd0;
   localparam logic [UPC_W-1:0]  UPC_INIT    = 6'd4;
   localparam logic [UPC_W-1:0]  UPC_WAKE    = 6'd8;
   localparam logic [LOOP_W-1:0] WAKE_REPEAT = 2'd2;

   typedef enum logic [1:0] {
      LINE_KEEP = 2'd0,
      LINE_CLR  = 2'd1,
      LINE_SET  = 2'd2,
      LINE_REQ  = 2'd3
   } line_op_type;

   typedef enum logic [1:0] {
      NIB_KEEP  = 2'd0,
      NIB_HI    = 2'd1,
      NIB_LO    = 2'd2,
      NIB_CONST = 2'd3
   } nib_op_type;

   typedef enum logic [2:0] {
      W_NONE  = 3'd0,
      W_BYTE  = 3'd1,
      W_1000  = 3'd2,
      W_2050  = 3'd3,
      W_5000  = 3'd4,
      W_15000 = 3'd5
   } wait_sel_type;

   typedef enum logic [1:0] {
      SEQ_NEXT = 2'd0,
      SEQ_LOOP = 2'd1,
      SEQ_DONE = 2'd2
   } seq_op_type;

   typedef struct packed {
      line_op_type       rs_op;
      line_op_type       e_op;
      nib_op_type        nib_op;
      logic [NIB_W-1:0]  nib_const;
      wait_sel_type      wait_sel;
      seq_op_type        seq;
      logic [UPC_W-1:0]  target;
   } ucode_type;

   typedef struct packed {
      logic [PIN_W-1:0]            rs;
      logic [PIN_W-1:0]            en;
      logic [NIB_W-1:0][PIN_W-1:0] db;
   } pin_map_type;

   function automatic ucode_type uw(line_op_type rs_op, line_op_type e_op,
                                    nib_op_type nib_op, logic [NIB_W-1:0] nib_const,
                                    wait_sel_type wait_sel, seq_op_type seq);
      ucode_type w;
      w.rs_op     = rs_op;
      w.e_op      = e_op;
      w.nib_op    = nib_op;
      w.nib_const = nib_const;
      w.wait_sel  = wait_sel;
      w.seq       = seq;
      w.target    = UPC_WAKE;
      return w;
   endfunction

   // Byte routine at 0, power-up program at 4.
   function automatic ucode_type ucode_rom(logic [UPC_W-1:0] upc);
      ucode_type w;
      unique case (upc)
         6'd0:  w = uw(LINE_REQ,  LINE_SET,  NIB_HI,    4'h0, W_NONE,  SEQ_NEXT);
         6'd1:  w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_NONE,  SEQ_NEXT);
         6'd2:  w = uw(LINE_KEEP, LINE_SET,  NIB_LO,    4'h0, W_NONE,  SEQ_NEXT);
         6'd3:  w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_BYTE,  SEQ_DONE);
         6'd4:  w = uw(LINE_KEEP, LINE_SET,  NIB_KEEP,  4'h0, W_NONE,  SEQ_NEXT);
         6'd5:  w = uw(LINE_SET,  LINE_KEEP, NIB_KEEP,  4'h0, W_15000, SEQ_NEXT);
         6'd6:  w = uw(LINE_CLR,  LINE_KEEP, NIB_KEEP,  4'h0, W_NONE,  SEQ_NEXT);
         6'd7:  w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_NONE,  SEQ_NEXT);
         6'd8:  w = uw(LINE_KEEP, LINE_SET,  NIB_CONST, 4'h3, W_NONE,  SEQ_NEXT);
         6'd9:  w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_5000,  SEQ_LOOP);
         6'd10: w = uw(LINE_KEEP, LINE_KEEP, NIB_KEEP,  4'h0, W_NONE,  SEQ_NEXT);
         6'd11: w = uw(LINE_KEEP, LINE_SET,  NIB_CONST, 4'h2, W_NONE,  SEQ_NEXT);
         6'd12: w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_1000,  SEQ_NEXT);
         // function set 0x28
         6'd13: w = uw(LINE_CLR,  LINE_SET,  NIB_CONST, 4'h2, W_NONE,  SEQ_NEXT);
         6'd14: w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_NONE,  SEQ_NEXT);
         6'd15: w = uw(LINE_KEEP, LINE_SET,  NIB_CONST, 4'h8, W_NONE,  SEQ_NEXT);
         6'd16: w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_BYTE,  SEQ_NEXT);
         // display off 0x08
         6'd17: w = uw(LINE_CLR,  LINE_SET,  NIB_CONST, 4'h0, W_NONE,  SEQ_NEXT);
         6'd18: w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_NONE,  SEQ_NEXT);
         6'd19: w = uw(LINE_KEEP, LINE_SET,  NIB_CONST, 4'h8, W_NONE,  SEQ_NEXT);
         6'd20: w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_BYTE,  SEQ_NEXT);
         // clear 0x01
         6'd21: w = uw(LINE_CLR,  LINE_SET,  NIB_CONST, 4'h0, W_NONE,  SEQ_NEXT);
         6'd22: w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_NONE,  SEQ_NEXT);
         6'd23: w = uw(LINE_KEEP, LINE_SET,  NIB_CONST, 4'h1, W_NONE,  SEQ_NEXT);
         6'd24: w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_2050,  SEQ_NEXT);
         // entry mode 0x06
         6'd25: w = uw(LINE_CLR,  LINE_SET,  NIB_CONST, 4'h0, W_NONE,  SEQ_NEXT);
         6'd26: w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_NONE,  SEQ_NEXT);
         6'd27: w = uw(LINE_KEEP, LINE_SET,  NIB_CONST, 4'h6, W_NONE,  SEQ_NEXT);
         6'd28: w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_BYTE,  SEQ_NEXT);
         // display on 0x0C
         6'd29: w = uw(LINE_CLR,  LINE_SET,  NIB_CONST, 4'h0, W_NONE,  SEQ_NEXT);
         6'd30: w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_NONE,  SEQ_NEXT);
         6'd31: w = uw(LINE_KEEP, LINE_SET,  NIB_CONST, 4'hC, W_NONE,  SEQ_NEXT);
         6'd32: w = uw(LINE_KEEP, LINE_CLR,  NIB_KEEP,  4'h0, W_BYTE,  SEQ_DONE);
         default: w = uw(LINE_KEEP, LINE_KEEP, NIB_KEEP, 4'h0, W_NONE, SEQ_DONE);
      endcase
      return w;
   endfunction

endpackage

@@ sv/lcd_4bit_write_sequencer.sv @@
// Top level: microcoded sequencer that turns LCD requests into shift register frames.
//
// Each accepted request is expanded by a small microcode program into frames for an
// 8-bit shift register wired to a character LCD in 4-bit mode, one frame per step,
// each with the microseconds to wait after latching it and a last flag on the final
// frame. Command, data, go-to, clear and home give 4 frames; init gives 33. The
// sequencer makes one step per clock while the result register is free, and each
// step loads one frame into it; the next request is taken once the last frame is
// loaded. Requests of an unknown kind are taken and give no frame. Pin positions
// may be changed through the csr port while idle.
module lcd_4bit_write_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lcdws_pkg::KIND_W-1:0]         req_kind,
   input  logic [lcdws_pkg::BYTE_W-1:0]         req_byte_value,
   input  logic [lcdws_pkg::COL_W-1:0]          req_column,
   input  logic                                 req_row,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lcdws_pkg::FRAME_BITS-1:0]     rsp_frame,
   output logic [lcdws_pkg::WAIT_W-1:0]         rsp_wait_us,
   output logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [lcdws_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lcdws_pkg::PIN_W-1:0]          csr_wdata
);
   import lcdws_pkg::*;

   logic                  run_ff, run_in;
   logic [UPC_W-1:0]      upc_ff, upc_in;
   logic [LOOP_W-1:0]     loop_ff, loop_in;
   logic [BYTE_W-1:0]     byte_ff, byte_in;
   logic                  rs_req_ff, rs_req_in;
   logic                  slow_ff, slow_in;
   logic [FRAME_BITS-1:0] shadow_ff, shadow_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WAIT_W-1:0]     rsp_wait_ff, rsp_wait_in;
   logic                  rsp_last_ff, rsp_last_in;
   pin_map_type           pins_ff, pins_in;

   ucode_type             ucw;
   logic [FRAME_BITS-1:0] frame_next;
   logic [WAIT_W-1:0]     wait_next;
   logic                  req_fire;
   logic                  known_kind;
   logic                  adv;
   logic [BYTE_W-1:0]     goto_byte;

   assign ucw        = ucode_rom(upc_ff);
   assign req_ready  = !run_ff;
   assign req_fire   = req_valid && req_ready;
   assign known_kind = (req_kind <= KIND_INIT);
   assign adv        = run_ff && (!rsp_valid_ff || rsp_ready);
   assign goto_byte  = OP_DDRAM | ({2'b00, req_column} + (req_row ? ROW_OFFSET : 8'h00));

   lcdws_frame_dp u_dp (
      .shadow     (shadow_ff),
      .pins       (pins_ff),
      .ucw        (ucw),
      .byte_value (byte_ff),
      .rs_level   (rs_req_ff),
      .slow       (slow_ff),
      .frame_next (frame_next),
      .wait_us    (wait_next)
   );

   always_comb begin
      run_in    = run_ff;
      upc_in    = upc_ff;
      loop_in   = loop_ff;
      byte_in   = byte_ff;
      rs_req_in = rs_req_ff;
      slow_in   = slow_ff;
      if (req_fire && known_kind) begin
         run_in    = 1'b1;
         upc_in    = (req_kind == KIND_INIT) ? UPC_INIT : UPC_BYTE;
         loop_in   = WAKE_REPEAT;
         rs_req_in = (req_kind == KIND_DATA);
         slow_in   = (req_kind == KIND_CLEAR) || (req_kind == KIND_HOME);
         priority case (req_kind)
            KIND_GOTO:  byte_in = goto_byte;
            KIND_CLEAR: byte_in = OP_CLEAR;
            KIND_HOME:  byte_in = OP_HOME;
            default:    byte_in = req_byte_value;
         endcase
      end else if (adv) begin
         unique case (ucw.seq)
            SEQ_LOOP: begin
               if (loop_ff != '0) begin
                  upc_in  = ucw.target;
                  loop_in = loop_ff - LOOP_W'(1);
               end else begin
                  upc_in = upc_ff + UPC_W'(1);
               end
            end
            SEQ_DONE: run_in = 1'b0;
            SEQ_NEXT: upc_in = upc_ff + UPC_W'(1);
            default:  run_in = 1'b0;
         endcase
      end
   end

   always_comb begin
      shadow_in    = shadow_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (adv) begin
         shadow_in    = frame_next;
         rsp_wait_in  = wait_next;
         rsp_last_in  = (ucw.seq == SEQ_DONE);
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      pins_in = pins_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RS_PIN:  pins_in.rs    = csr_wdata;
            CSR_EN_PIN:  pins_in.en    = csr_wdata;
            CSR_DB4_PIN: pins_in.db[0] = csr_wdata;
            CSR_DB5_PIN: pins_in.db[1] = csr_wdata;
            CSR_DB6_PIN: pins_in.db[2] = csr_wdata;
            CSR_DB7_PIN: pins_in.db[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         upc_ff       <= UPC_BYTE;
         loop_ff      <= '0;
         shadow_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         pins_ff.rs   <= RST_RS_PIN;
         pins_ff.en   <= RST_EN_PIN;
         pins_ff.db   <= {RST_DB7_PIN, RST_DB6_PIN, RST_DB5_PIN, RST_DB4_PIN};
      end else begin
         run_ff       <= run_in;
         upc_ff       <= upc_in;
         loop_ff      <= loop_in;
         shadow_ff    <= shadow_in;
         rsp_valid_ff <= rsp_valid_in;
         pins_ff      <= pins_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rs_req_ff   <= rs_req_in;
      slow_ff     <= slow_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_frame   = shadow_ff;
   assign rsp_wait_us = rsp_wait_ff;
   assign rsp_last    = rsp_last_ff;

   a_step_loads_beat: assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_valid)
      else $error("sequencer step did not load a result beat");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      adv && ucw.seq == SEQ_DONE |=> !run_ff && rsp_last)
      else $error("final step did not end the request");

   a_init_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_kind == KIND_INIT |=> run_ff && upc_ff == UPC_INIT)
      else $error("init request did not enter the power-up program");

endmodule

@@ sv/lcdws_frame_dp.sv @@
// Frame datapath: applies one control word to the shadow frame and picks the wait.
module lcdws_frame_dp (
   input  logic [lcdws_pkg::FRAME_BITS-1:0] shadow,
   input  lcdws_pkg::pin_map_type           pins,
   input  lcdws_pkg::ucode_type             ucw,
   input  logic [lcdws_pkg::BYTE_W-1:0]     byte_value,
   input  logic                             rs_level,
   input  logic                             slow,
   output logic [lcdws_pkg::FRAME_BITS-1:0] frame_next,
   output logic [lcdws_pkg::WAIT_W-1:0]     wait_us
);
   import lcdws_pkg::*;

   logic [NIB_W-1:0] nib;

   always_comb begin
      unique case (ucw.nib_op)
         NIB_HI:    nib = byte_value[BYTE_W-1:NIB_W];
         NIB_LO:    nib = byte_value[NIB_W-1:0];
         NIB_CONST: nib = ucw.nib_const;
         NIB_KEEP:  nib = '0;
         default:   nib = '0;
      endcase
   end

   // RS, then E, then DB4..DB7: later writes win on shared bits
   always_comb begin
      frame_next = shadow;
      unique case (ucw.rs_op)
         LINE_CLR: frame_next[pins.rs] = 1'b0;
         LINE_SET: frame_next[pins.rs] = 1'b1;
         LINE_REQ: frame_next[pins.rs] = rs_level;
         LINE_KEEP: ;
         default: ;
      endcase
      unique case (ucw.e_op)
         LINE_CLR: frame_next[pins.en] = 1'b0;
         LINE_SET: frame_next[pins.en] = 1'b1;
         LINE_REQ: frame_next[pins.en] = rs_level;
         LINE_KEEP: ;
         default: ;
      endcase
      if (ucw.nib_op != NIB_KEEP) begin
         for (int i = 0; i < NIB_W; i++) begin
            frame_next[pins.db[i]] = nib[i];
         end
      end
   end

   always_comb begin
      unique case (ucw.wait_sel)
         W_BYTE:  wait_us = slow ? WAIT_WRITE + WAIT_SLOW : WAIT_WRITE;
         W_1000:  wait_us = WAIT_NIB2;
         W_2050:  wait_us = WAIT_WRITE + WAIT_SLOW;
         W_5000:  wait_us = WAIT_WAKE;
         W_15000: wait_us = WAIT_POWER;
         W_NONE:  wait_us = '0;
         default: wait_us = '0;
      endcase
   end

endmodule

@@ tb/sv/lcd_4bit_write_sequencer_tb.sv @@
// Self-checking testbench for the LCD 4-bit write sequencer: directed and random requests.
module lcd_4bit_write_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcdws_pkg::*;

   localparam int LIMIT_CYCLES = 400_000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 45;
   localparam int SETTLE       = 50;
   localparam int HOLD_AT_BEAT = 100;
   localparam int HOLD_CYCLES  = 600;

   localparam logic [KIND_W-1:0] KIND_BAD_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_BAD_HI = 3'd7;

   // function set, display off, clear, entry mode, display on
   localparam logic [BYTE_W-1:0] WAKE_CMDS [5] = '{8'h28, 8'h08, OP_CLEAR, 8'h06, 8'h0C};

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] value;
      logic [COL_W-1:0]  column;
      logic              row;
   } lcd_req_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] frame;
      logic [WAIT_W-1:0]     wait_us;
      logic                  last;
   } lcd_frame_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [BYTE_W-1:0]     req_byte_value = '0;
   logic [COL_W-1:0]      req_column = '0;
   logic                  req_row = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [FRAME_BITS-1:0] rsp_frame;
   logic [WAIT_W-1:0]     rsp_wait_us;
   logic                  rsp_last;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [PIN_W-1:0]      csr_wdata = '0;

   lcd_req_type   pending_reqs[$];
   lcd_frame_type expected_frames[$];

   logic [FRAME_BITS-1:0] model_lines;
   logic [PIN_W-1:0]      pin_pos [6];
   int                    seq_len;

   logic req_beat = 1'b0;
   int   req_beats = 0;
   int   init_beats = 0;
   int   frames_checked = 0;
   int   mismatches = 0;

   lcd_4bit_write_sequencer dut (.*);

   always #2 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic void set_line(logic [PIN_W-1:0] pos, logic level);
      model_lines[pos] = level;
   endfunction

   function automatic void emit_frame();
      lcd_frame_type f;
      f.frame   = model_lines;
      f.wait_us = '0;
      f.last    = 1'b0;
      expected_frames.push_back(f);
      seq_len++;
   endfunction

   function automatic void add_wait(logic [WAIT_W-1:0] us);
      if (seq_len > 0)
         expected_frames[expected_frames.size()-1].wait_us += us;
   endfunction

   function automatic void put_nibble(logic [NIB_W-1:0] n);
      set_line(pin_pos[CSR_DB4_PIN], n[0]);
      set_line(pin_pos[CSR_DB5_PIN], n[1]);
      set_line(pin_pos[CSR_DB6_PIN], n[2]);
      set_line(pin_pos[CSR_DB7_PIN], n[3]);
   endfunction

   function automatic void write_byte(logic [BYTE_W-1:0] b, logic rs);
      set_line(pin_pos[CSR_RS_PIN], rs);
      set_line(pin_pos[CSR_EN_PIN], 1'b1);
      put_nibble(b[7:4]);
      emit_frame();
      set_line(pin_pos[CSR_EN_PIN], 1'b0);
      emit_frame();
      set_line(pin_pos[CSR_EN_PIN], 1'b1);
      put_nibble(b[3:0]);
      emit_frame();
      set_line(pin_pos[CSR_EN_PIN], 1'b0);
      emit_frame();
      add_wait(WAIT_WRITE);
   endfunction

   function automatic void expand_request(lcd_req_type r);
      logic [BYTE_W-1:0] addr;
      seq_len = 0;
      case (r.kind)
         KIND_CMD:  write_byte(r.value, 1'b0);
         KIND_DATA: write_byte(r.value, 1'b1);
         KIND_GOTO: begin
            addr = BYTE_W'(r.column) + (r.row ? ROW_OFFSET : 8'h00);
            write_byte(OP_DDRAM | addr, 1'b0);
         end
         KIND_CLEAR: begin
            write_byte(OP_CLEAR, 1'b0);
            add_wait(WAIT_SLOW);
         end
         KIND_HOME: begin
            write_byte(OP_HOME, 1'b0);
            add_wait(WAIT_SLOW);
         end
         KIND_INIT: begin
            set_line(pin_pos[CSR_EN_PIN], 1'b1);
            emit_frame();
            set_line(pin_pos[CSR_RS_PIN], 1'b1);
            emit_frame();
            add_wait(WAIT_POWER);
            set_line(pin_pos[CSR_RS_PIN], 1'b0);
            emit_frame();
            set_line(pin_pos[CSR_EN_PIN], 1'b0);
            emit_frame();
            for (int i = 0; i < 3; i++) begin
               set_line(pin_pos[CSR_EN_PIN], 1'b1);
               put_nibble(4'h3);
               emit_frame();
               set_line(pin_pos[CSR_EN_PIN], 1'b0);
               emit_frame();
               add_wait(WAIT_WAKE);
            end
            emit_frame();
            set_line(pin_pos[CSR_EN_PIN], 1'b1);
            put_nibble(4'h2);
            emit_frame();
            set_line(pin_pos[CSR_EN_PIN], 1'b0);
            emit_frame();
            add_wait(WAIT_NIB2);
            for (int i = 0; i < 5; i++) begin
               write_byte(WAKE_CMDS[i], 1'b0);
               if (WAKE_CMDS[i] == OP_CLEAR)
                  add_wait(WAIT_SLOW);
            end
         end
         default: ;
      endcase
      if (seq_len > 0)
         expected_frames[expected_frames.size()-1].last = 1'b1;
   endfunction

   // ---------------- driver ----------------
   int gap_left = 0;
   int burst_left = 0;

   always @(negedge clock) begin : drv
      lcd_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_beat) begin
         // hold the beat until it is taken
      end else if (gap_left != 0) begin
         gap_left = gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
         item = pending_reqs.pop_front();
         req_kind       <= item.kind;
         req_byte_value <= item.value;
         req_column     <= item.column;
         req_row        <= item.row;
         req_valid      <= 1'b1;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         end else begin
            burst_left = burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------- receiver ----------------
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;
   int          hold_left = 0;
   logic        hold_armed = 1'b1;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_armed && req_beats >= HOLD_AT_BEAT) begin
            hold_left  = HOLD_CYCLES;
            hold_armed = 1'b0;
         end
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
         end else begin
            rx_left = rx_left - 1;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= ($urandom_range(0, 2) == 0);
               default:   rsp_ready <= ((rx_left % 5) >= 2);
            endcase
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin : mon
      lcd_frame_type want;
      lcd_req_type   seen;
      if (reset) begin
         req_beat <= 1'b0;
      end else begin
         req_beat <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            frames_checked++;
            if (expected_frames.size() == 0) begin
               $error("unexpected beat: frame %h wait_us %0d last %b",
                      rsp_frame, rsp_wait_us, rsp_last);
               mismatches++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_frame !== want.frame) begin
                  $error("frame: expected %h, got %h", want.frame, rsp_frame);
                  mismatches++;
               end
               if (rsp_wait_us !== want.wait_us) begin
                  $error("wait_us: expected %0d, got %0d", want.wait_us, rsp_wait_us);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            seen = '{req_kind, req_byte_value, req_column, req_row};
            expand_request(seen);
            req_beats++;
            if (req_kind == KIND_INIT)
               init_beats++;
         end
      end
   end

   // ---------------- stimulus ----------------
   function automatic void queue_req(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] value,
                                     logic [COL_W-1:0] column, logic row);
      pending_reqs.push_back('{kind, value, column, row});
   endfunction

   function automatic lcd_req_type random_req();
      lcd_req_type r;
      int          pick;
      pick     = $urandom_range(0, 99);
      r.value  = BYTE_W'($urandom);
      r.column = COL_W'($urandom);
      r.row    = 1'($urandom);
      if (pick < 28)      r.kind = KIND_CMD;
      else if (pick < 55) r.kind = KIND_DATA;
      else if (pick < 72) r.kind = KIND_GOTO;
      else if (pick < 80) r.kind = KIND_CLEAR;
      else if (pick < 88) r.kind = KIND_HOME;
      else if (pick < 95) r.kind = KIND_INIT;
      else                r.kind = pick[0] ? KIND_BAD_HI : KIND_BAD_LO;
      return r;
   endfunction

   task automatic load_pins(input logic [PIN_W-1:0] rs, en, d4, d5, d6, d7);
      logic [PIN_W-1:0]     vals [6];
      logic [CSR_IDX_W-1:0] idx  [6];
      vals = '{rs, en, d4, d5, d6, d7};
      idx  = '{CSR_RS_PIN, CSR_EN_PIN, CSR_DB4_PIN, CSR_DB5_PIN, CSR_DB6_PIN, CSR_DB7_PIN};
      for (int i = 0; i < 6; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         pin_pos[idx[i]] = vals[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_frames.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      model_lines = '0;
      pin_pos = '{RST_RS_PIN, RST_EN_PIN, RST_DB4_PIN, RST_DB5_PIN, RST_DB6_PIN, RST_DB7_PIN};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass on the reset pin map
      queue_req(KIND_INIT,   8'h00, 6'd0,  1'b0);
      queue_req(KIND_CMD,    8'h00, 6'd0,  1'b0);
      queue_req(KIND_CMD,    8'hFF, 6'd63, 1'b1);
      queue_req(KIND_DATA,   8'hFF, 6'd0,  1'b0);
      queue_req(KIND_DATA,   8'h00, 6'd63, 1'b1);
      queue_req(KIND_DATA,   8'hA5, 6'd21, 1'b0);
      queue_req(KIND_DATA,   8'h5A, 6'd42, 1'b1);
      queue_req(KIND_GOTO,   8'hFF, 6'd0,  1'b0);
      queue_req(KIND_GOTO,   8'h00, 6'd39, 1'b1);
      queue_req(KIND_GOTO,   8'h3C, 6'd40, 1'b0);
      queue_req(KIND_GOTO,   8'hC3, 6'd63, 1'b1);
      queue_req(KIND_CLEAR,  8'hFF, 6'd63, 1'b1);
      queue_req(KIND_HOME,   8'hFF, 6'd63, 1'b1);
      queue_req(KIND_BAD_LO, 8'hFF, 6'd63, 1'b1);
      queue_req(KIND_BAD_HI, 8'h00, 6'd0,  1'b0);
      queue_req(KIND_CMD,    8'h01, 6'd5,  1'b1);
      queue_req(KIND_INIT,   8'hFF, 6'd63, 1'b1);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: load_pins(3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7);
            1: load_pins(3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0);
            2: load_pins(3'd7, 3'd6, 3'd3, 3'd2, 3'd1, 3'd0);
            3: load_pins(RST_RS_PIN, RST_EN_PIN, RST_DB4_PIN, RST_DB5_PIN,
                         RST_DB6_PIN, RST_DB7_PIN);
            default: load_pins(PIN_W'($urandom), PIN_W'($urandom), PIN_W'($urandom),
                               PIN_W'($urandom), PIN_W'($urandom), PIN_W'($urandom));
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++)
            pending_reqs.push_back(random_req());
         drain();
      end

      $display("Run covered %0d requests (%0d init) and %0d frames checked,",
               req_beats, init_beats, frames_checked);
      $display("across %0d pin maps including fully colliding ones.", PHASES + 1);
      if (mismatches == 0 && expected_frames.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ lcd_4bit_write_sequencer.f @@
sv/lcdws_pkg.sv
sv/lcdws_frame_dp.sv
sv/lcd_4bit_write_sequencer.sv
tb/sv/lcd_4bit_write_sequencer_tb.sv
